>>> sv/mhbp_pkg.sv
// Shared constants and result type for the message header byte parser.
package mhbp_pkg;

    // Field sizes in bytes
    localparam int MAGIC_BYTES  = 4;
    localparam int TYPE_BYTES   = 12;
    localparam int LENGTH_BYTES = 8;

    // Derived widths
    localparam int MAGIC_W     = 8 * MAGIC_BYTES;
    localparam int MAGIC_REG_W = 32;
    localparam int LENGTH_W    = 64;
    localparam int PHASE_W     = 4;
    localparam int TYPE_IDX_W  = 4;

    // Magic word after reset
    localparam logic [MAGIC_REG_W-1:0] MAGIC_RESET = 32'd422021;

    // One result, as reported after every byte
    typedef struct packed {
        logic [LENGTH_W-1:0]   payload_length;
        logic [7:0]            type_byte;
        logic [TYPE_IDX_W-1:0] type_byte_index;
        logic                  type_byte_valid;
        logic [PHASE_W-1:0]    phase;
    } result_t;

endpackage

>>> sv/message_header_byte_parser.sv
// Top level: stream handshakes, input register, magic register and parser core.
//
//  channel | direction | transfer when          | content
//  --------+-----------+------------------------+--------------------------------------
//  s_*     | in        | s_tvalid & s_tready    | one message byte or a restart
//  m_*     | out       | m_tvalid & m_tready    | phase, type byte echo, length so far
//  cfg_*   | in        | cfg_valid & cfg_ready  | expected magic word
//
// Each byte passes the input register, then the parser into the result register.
// One byte is taken every cycle while the output is not stalled; the only loop is
// the parser state update.
// Reset (rst_n low, asynchronous) returns the parser to the magic phase and
// reloads the magic word. A stalled output holds its result; the input register
// frees as soon as its byte moves into the result register.
module message_header_byte_parser
    import mhbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [79:0]            m_tdata,   // [3:0] phase, [7:4] type_byte_index,
                                              // [15:8] type_byte, [79:16] payload_length
    output logic                   m_tuser,   // [0] type_byte_valid
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [MAGIC_REG_W-1:0] cfg_data
);

    logic                   in_valid_reg;
    logic                   in_kind_reg;
    logic [7:0]             in_byte_reg;
    logic                   out_valid_reg;
    logic [MAGIC_REG_W-1:0] magic_reg;
    logic                   step;
    result_t                result;

    // Move a byte into the result register when that register is free or drains
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    // Input and output valid flags, magic register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            magic_reg     <= MAGIC_RESET;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (step)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (cfg_valid)
                magic_reg <= cfg_data;
        end
    end

    // Capture the input payload on each transfer
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    mhbp_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .restart        (in_kind_reg),
        .rx_byte        (in_byte_reg),
        .expected_magic (magic_reg),
        .result         (result)
    );

    // Pack the result onto the master side
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = result.type_byte_valid;
    assign m_tdata  = {result.payload_length, result.type_byte,
                       result.type_byte_index, result.phase};

endmodule

>>> sv/mhbp_parser.sv
// Parser state machine: phase, byte counter, magic and length shifters, result register.
module mhbp_parser
    import mhbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic                   restart,
    input  logic [7:0]             rx_byte,
    input  logic [MAGIC_REG_W-1:0] expected_magic,
    output result_t                result
);

    typedef enum logic [PHASE_W-1:0] {
        PH_MAGIC        = 4'd0,
        PH_MAGIC_DONE   = 4'd1,
        PH_TYPE         = 4'd2,
        PH_TYPE_DONE    = 4'd3,
        PH_LENGTH       = 4'd4,
        PH_LENGTH_DONE  = 4'd5,
        PH_PAYLOAD      = 4'd6,
        PH_PAYLOAD_DONE = 4'd7,
        PH_DISCARD      = 4'd8
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_W-1:0]    remaining_reg, remaining_next;
    logic [MAGIC_REG_W-1:0] magic_reg, magic_next;
    logic [LENGTH_W-1:0]    length_reg, length_next;
    result_t                result_reg, result_next;

    // Work out the next parser state and the result for one byte
    always_comb
    begin
        logic [LENGTH_W-1:0] rem_eff;
        logic [LENGTH_W-1:0] len_eff;

        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        magic_next     = magic_reg;
        length_next    = length_reg;
        rem_eff        = remaining_reg;
        len_eff        = length_reg;

        result_next                 = '0;

        if (restart)
        begin
            phase_next     = PH_MAGIC;
            remaining_next = LENGTH_W'(MAGIC_BYTES - 1);
            magic_next     = '0;
            length_next    = '0;
        end
        else
        begin
            case (phase_reg)
                PH_MAGIC:
                begin
                    magic_next = (magic_reg << 8) | MAGIC_REG_W'(rx_byte);
                    if (remaining_reg == '0)
                    begin
                        if (magic_next[MAGIC_W-1:0] == expected_magic[MAGIC_W-1:0])
                            phase_next = PH_MAGIC_DONE;
                        else
                            phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 1'b1;
                    end
                end

                PH_MAGIC_DONE, PH_TYPE:
                begin
                    // A byte after the magic word opens the type field
                    if (phase_reg == PH_MAGIC_DONE)
                        rem_eff = LENGTH_W'(TYPE_BYTES - 1);
                    result_next.type_byte_valid = 1'b1;
                    result_next.type_byte_index = TYPE_IDX_W'(TYPE_BYTES - 1)
                                                  - rem_eff[TYPE_IDX_W-1:0];
                    result_next.type_byte       = rx_byte;
                    if (rem_eff == '0)
                    begin
                        phase_next     = PH_TYPE_DONE;
                        remaining_next = '0;
                    end
                    else
                    begin
                        phase_next     = PH_TYPE;
                        remaining_next = rem_eff - 1'b1;
                    end
                end

                PH_TYPE_DONE, PH_LENGTH:
                begin
                    // A byte after the type field opens the length field
                    if (phase_reg == PH_TYPE_DONE)
                    begin
                        rem_eff = LENGTH_W'(LENGTH_BYTES - 1);
                        len_eff = '0;
                    end
                    length_next = (len_eff << 8) | LENGTH_W'(rx_byte);
                    if (rem_eff == '0)
                    begin
                        phase_next     = PH_LENGTH_DONE;
                        remaining_next = '0;
                    end
                    else
                    begin
                        phase_next     = PH_LENGTH;
                        remaining_next = rem_eff - 1'b1;
                    end
                end

                PH_LENGTH_DONE, PH_PAYLOAD:
                begin
                    // A byte after the length field loads the payload count
                    if (phase_reg == PH_LENGTH_DONE)
                        rem_eff = length_reg;
                    if (rem_eff <= LENGTH_W'(1))
                    begin
                        phase_next     = PH_PAYLOAD_DONE;
                        remaining_next = '0;
                    end
                    else
                    begin
                        phase_next     = PH_PAYLOAD;
                        remaining_next = rem_eff - 1'b1;
                    end
                end

                default:
                begin
                    phase_next = PH_DISCARD;
                end
            endcase
        end

        result_next.phase          = phase_next;
        result_next.payload_length = length_next;
    end

    // Hold state and result; advance on each processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            remaining_reg <= LENGTH_W'(MAGIC_BYTES - 1);
            magic_reg     <= '0;
            length_reg    <= '0;
            result_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            magic_reg     <= magic_next;
            length_reg    <= length_next;
            result_reg    <= result_next;
        end
    end

    assign result = result_reg;

endmodule

>>> test/header_parse_checker.sv
// Checker that predicts the parser's reports from its input transfers and compares them.
module header_parse_checker
    import mhbp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] data_byte
    input  logic                   s_tuser,   // [0] kind
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [79:0]            m_tdata,   // [3:0] phase, [7:4] type_byte_index,
                                              // [15:8] type_byte, [79:16] payload_length
    input  logic                   m_tuser,   // [0] type_byte_valid
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [MAGIC_REG_W-1:0] cfg_data,
    output int                     mismatch_count,
    output int                     reports_due
);

    typedef enum logic [PHASE_W-1:0] {
        PH_MAGIC        = 4'd0,
        PH_MAGIC_DONE   = 4'd1,
        PH_TYPE         = 4'd2,
        PH_TYPE_DONE    = 4'd3,
        PH_LENGTH       = 4'd4,
        PH_LENGTH_DONE  = 4'd5,
        PH_PAYLOAD      = 4'd6,
        PH_PAYLOAD_DONE = 4'd7,
        PH_DISCARD      = 4'd8
    } phase_t;

    localparam int REPORT_LIMIT = 10;

    // Parser state as predicted, plus the magic register copy
    phase_t                 cur_phase;
    logic [LENGTH_W-1:0]    bytes_left;
    logic [MAGIC_REG_W-1:0] magic_acc;
    logic [LENGTH_W-1:0]    length_acc;
    logic [MAGIC_REG_W-1:0] magic_word;
    result_t                expected_reports[$];

    function automatic void restart_parser();
        cur_phase  = PH_MAGIC;
        bytes_left = LENGTH_W'(MAGIC_BYTES - 1);
        magic_acc  = '0;
        length_acc = '0;
    endfunction

    // Advance the predicted parser by one byte or restart and return its report
    function automatic result_t parse_byte(input logic restart, input logic [7:0] value);
        result_t rep;
        rep = '0;
        if (restart)
        begin
            restart_parser();
        end
        else
        begin
            // a byte after a completed field is the first byte of the next one
            case (cur_phase)
                PH_MAGIC_DONE:
                begin
                    cur_phase  = PH_TYPE;
                    bytes_left = LENGTH_W'(TYPE_BYTES - 1);
                end
                PH_TYPE_DONE:
                begin
                    cur_phase  = PH_LENGTH;
                    bytes_left = LENGTH_W'(LENGTH_BYTES - 1);
                    length_acc = '0;
                end
                PH_LENGTH_DONE:
                begin
                    cur_phase  = PH_PAYLOAD;
                    bytes_left = length_acc;
                end
                default: ;
            endcase

            case (cur_phase)
                PH_MAGIC:
                begin
                    magic_acc = {magic_acc[MAGIC_REG_W-9:0], value};
                    if (bytes_left != 0)
                        bytes_left--;
                    else if (magic_acc[MAGIC_W-1:0] == magic_word[MAGIC_W-1:0])
                        cur_phase = PH_MAGIC_DONE;
                    else
                        cur_phase = PH_DISCARD;
                end
                PH_TYPE:
                begin
                    rep.type_byte_valid = 1'b1;
                    rep.type_byte_index = TYPE_IDX_W'(TYPE_BYTES - 1 - int'(bytes_left));
                    rep.type_byte       = value;
                    if (bytes_left == 0)
                        cur_phase = PH_TYPE_DONE;
                    else
                        bytes_left--;
                end
                PH_LENGTH:
                begin
                    length_acc = {length_acc[LENGTH_W-9:0], value};
                    if (bytes_left == 0)
                        cur_phase = PH_LENGTH_DONE;
                    else
                        bytes_left--;
                end
                PH_PAYLOAD:
                begin
                    // zero and one both end on the first payload byte
                    if (bytes_left <= 1)
                    begin
                        bytes_left = '0;
                        cur_phase  = PH_PAYLOAD_DONE;
                    end
                    else
                    begin
                        bytes_left--;
                    end
                end
                default: cur_phase = PH_DISCARD;
            endcase
        end
        rep.phase          = cur_phase;
        rep.payload_length = length_acc;
        return rep;
    endfunction

    function automatic string show(input result_t rep);
        return $sformatf("phase %0d type %0b/%0d/%h length %h", rep.phase,
                         rep.type_byte_valid, rep.type_byte_index, rep.type_byte,
                         rep.payload_length);
    endfunction

    // Count a failure and say whether it is still worth printing
    function automatic bit tally_failure();
        mismatch_count++;
        return mismatch_count <= REPORT_LIMIT;
    endfunction

    // Compare result transfers first, then queue the prediction for an input transfer
    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            restart_parser();
            magic_word = MAGIC_RESET;
            expected_reports.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.phase           = m_tdata[3:0];
                seen.type_byte_index = m_tdata[7:4];
                seen.type_byte       = m_tdata[15:8];
                seen.payload_length  = m_tdata[79:16];
                seen.type_byte_valid = m_tuser;
                if (expected_reports.size() == 0)
                begin
                    if (tally_failure())
                        $display("%0t: report with none expected, got %s", $time, show(seen));
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (seen.phase !== want.phase
                        || seen.type_byte_valid !== want.type_byte_valid
                        || seen.type_byte_index !== want.type_byte_index
                        || seen.type_byte !== want.type_byte
                        || seen.payload_length !== want.payload_length)
                    begin
                        if (tally_failure())
                            $display("%0t: report mismatch, expected %s, got %s",
                                     $time, show(want), show(seen));
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_reports.push_back(parse_byte(s_tuser, s_tdata));
            if (cfg_valid && cfg_ready)
                magic_word = cfg_data;
        end
        reports_due = expected_reports.size();
    end

endmodule

>>> test/tb_top.sv
// Top of the parser testbench: clock, reset, byte stimulus, back-pressure and verdict.
module tb_top;
    import mhbp_pkg::*;

    localparam logic KIND_DATA       = 1'b0;
    localparam logic KIND_RESTART    = 1'b1;
    localparam int   ITEM_TARGET     = 1950;
    localparam int   HOLD_OFF_CYCLES = 200;
    localparam int   SETTLE_CYCLES   = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [79:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [MAGIC_REG_W-1:0] cfg_data;

    int                     mismatch_count;
    int                     reports_due;
    int                     src_idle_pct;
    int                     snk_idle_pct;
    int                     bytes_sent;
    bit                     hold_req;
    logic [MAGIC_REG_W-1:0] magic_now;

    message_header_byte_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    header_parse_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .reports_due    (reports_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: random stalls, and one long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Offer one byte or restart after a random gap and hold it until the transfer
    task automatic send_byte(input logic kind, input logic [7:0] value);
        bit taken;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= value;
        do
        begin
            @(negedge clk);
            taken = s_tready;
            @(posedge clk);
        end
        while (!taken);
        bytes_sent++;
    endtask

    // Stop offering and wait for every outstanding report
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (reports_due != 0);
        @(posedge clk);
    endtask

    task automatic write_magic(input logic [MAGIC_REG_W-1:0] value);
        bit taken;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        magic_now = value;
    endtask

    // Build one message, mostly well-formed, sometimes noise, a bad magic or cut short
    task automatic send_message();
        logic [7:0]             frame[$];
        logic [MAGIC_REG_W-1:0] magic;
        logic [LENGTH_W-1:0]    len;
        int                     pick;
        int                     keep;
        int                     payload_n;
        int                     i;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            repeat ($urandom_range(1, 30)) frame.push_back(8'($urandom));
        end
        else
        begin
            magic = magic_now;
            if (pick < 15)
                magic ^= MAGIC_REG_W'(1) << $urandom_range(MAGIC_REG_W - 1);
            for (i = MAGIC_BYTES - 1; i >= 0; i--)
                frame.push_back(magic[8*i +: 8]);
            repeat (TYPE_BYTES) frame.push_back(8'($urandom));

            pick = $urandom_range(99);
            if (pick < 20)
                len = '0;
            else if (pick < 30)
                len = LENGTH_W'(1);
            else if (pick < 75)
                len = LENGTH_W'($urandom_range(2, 24));
            else if (pick < 80)
                len = '1;
            else
                len = {$urandom, $urandom};
            for (i = LENGTH_BYTES - 1; i >= 0; i--)
                frame.push_back(len[8*i +: 8]);

            // long payloads are never finished, only started
            if (len > 40)
                payload_n = $urandom_range(0, 8);
            else if (len == 0)
                payload_n = 1;
            else
                payload_n = int'(len);
            repeat (payload_n) frame.push_back(8'($urandom));
            repeat ($urandom_range(0, 3)) frame.push_back(8'($urandom));
        end

        keep = frame.size();
        if ($urandom_range(9) == 0)
            keep = $urandom_range(0, frame.size());
        for (i = 0; i < keep; i++)
            send_byte(KIND_DATA, frame[i]);
        if ($urandom_range(19) != 0)
            send_byte(KIND_RESTART, 8'($urandom));
    endtask

    // Reset, directed header, then random messages over three idling stages
    initial
    begin
        int i;
        int stage;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = KIND_DATA;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        hold_req     = 1'b0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        bytes_sent   = 0;
        magic_now    = MAGIC_RESET;
        stage        = -1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full header with the reset magic, extreme type bytes and a zero length
        for (i = MAGIC_BYTES - 1; i >= 0; i--)
            send_byte(KIND_DATA, magic_now[8*i +: 8]);
        for (i = 0; i < TYPE_BYTES; i++)
            send_byte(KIND_DATA, (i % 2 == 0) ? 8'h00 : 8'hFF);
        repeat (LENGTH_BYTES) send_byte(KIND_DATA, 8'h00);
        send_byte(KIND_DATA, 8'hFF);
        send_byte(KIND_DATA, 8'h00);
        send_byte(KIND_RESTART, 8'hFF);

        while (bytes_sent < ITEM_TARGET)
        begin
            if (bytes_sent * 3 / ITEM_TARGET != stage)
            begin
                stage = bytes_sent * 3 / ITEM_TARGET;
                case (stage)
                    0:
                    begin
                        src_idle_pct = 10;
                        snk_idle_pct = 47;
                        write_magic($urandom);
                    end
                    1:
                    begin
                        src_idle_pct = 47;
                        snk_idle_pct = 10;
                        write_magic('1);
                    end
                    default:
                    begin
                        src_idle_pct = 0;
                        snk_idle_pct = 0;
                        write_magic('0);
                        hold_req = 1'b1;
                    end
                endcase
            end
            else if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(3))
                    0:       write_magic('0);
                    1:       write_magic('1);
                    2:       write_magic(MAGIC_RESET);
                    default: write_magic($urandom);
                endcase
            end
            send_message();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && reports_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
